// ===== rtl/core/alu16_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu16_pkg
// Shared types, opcodes and pipeline constants for the 16-bit flag ALU.
// ----------------------------------------------------------------------------
package alu16_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned NumCells = WordW;         // one quotient bit per cell
  localparam int unsigned Latency = NumCells + 2;   // front + cells + output

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_AND = 4'd2;
  localparam logic [3:0] OP_OR  = 4'd3;
  localparam logic [3:0] OP_XOR = 4'd4;
  localparam logic [3:0] OP_NOT = 4'd5;
  localparam logic [3:0] OP_SHL = 4'd6;
  localparam logic [3:0] OP_SHR = 4'd7;
  localparam logic [3:0] OP_MUL = 4'd8;
  localparam logic [3:0] OP_DIV = 4'd9;

  typedef struct packed {
    logic [3:0]       opcode;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
    logic             add_carry;
    logic [7:0]       shift_amount;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic             zero_flag;
    logic             negative_flag;
    logic             carry_flag;
    logic             overflow_flag;
  } rsp_t;

  // One slot of the cell chain.
  typedef struct packed {
    logic             valid;
    logic             is_div;
    logic             div_zero;
    logic [WordW-1:0] rem;   // partial remainder
    logic [WordW-1:0] acc;   // dividend bits out, quotient bits in
    logic [WordW-1:0] dvs;   // divisor
    rsp_t             res;   // finished result for non-divide ops
  } stage_t;

endpackage

// ===== rtl/core/alu16_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu16_front
// Entry stage: evaluates all non-divide ops and seeds the divide chain.
// ----------------------------------------------------------------------------
module alu16_front import alu16_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   take_i,
  input  req_t   req_i,
  output stage_t stage_o
);

  logic [WordW:0]     add_w;
  logic [WordW:0]     sub_w;
  logic [2*WordW-1:0] shl_w;
  logic [2*WordW-1:0] mul_w;
  logic [3:0]         sh;
  logic [3:0]         sh_m1;
  logic [WordW-1:0]   a, b, r;
  logic               c, v, nclr;
  rsp_t               res;
  stage_t             stage_d, stage_q;

  always_comb begin
    a     = req_i.operand_a;
    b     = req_i.operand_b;
    sh    = req_i.shift_amount[3:0];
    sh_m1 = sh - 4'd1;
    add_w = {1'b0, a} + {1'b0, b} + {{WordW{1'b0}}, req_i.add_carry};
    sub_w = {1'b0, a} - {1'b0, b};
    shl_w = {{WordW{1'b0}}, a} << sh;
    mul_w = {{WordW{1'b0}}, a} * {{WordW{1'b0}}, b};
    r     = '0;
    c     = 1'b0;
    v     = 1'b0;
    nclr  = 1'b0;
    case (req_i.opcode)
      OP_ADD: begin
        r = add_w[WordW-1:0];
        c = add_w[WordW];
        v = ~(a[WordW-1] ^ b[WordW-1]) & (a[WordW-1] ^ r[WordW-1]);
      end
      OP_SUB: begin
        r = sub_w[WordW-1:0];
        c = ~sub_w[WordW];
        v = (a[WordW-1] ^ b[WordW-1]) & (a[WordW-1] ^ r[WordW-1]);
      end
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_XOR: r = a ^ b;
      OP_NOT: r = ~a;
      OP_SHL: begin
        r = shl_w[WordW-1:0];
        c = |shl_w[2*WordW-1:WordW];
      end
      OP_SHR: begin
        r    = a >> sh;
        c    = (sh != 4'd0) ? a[sh_m1] : 1'b0;
        nclr = 1'b1;
      end
      OP_MUL: begin
        r = mul_w[WordW-1:0];
        c = |mul_w[2*WordW-1:WordW];
      end
      default: ;
    endcase
    res.result_word   = r;
    res.zero_flag     = (r == '0) && (req_i.opcode <= OP_DIV);
    res.negative_flag = r[WordW-1] & ~nclr;
    res.carry_flag    = c;
    res.overflow_flag = v;

    stage_d.valid    = take_i;
    stage_d.is_div   = (req_i.opcode == OP_DIV);
    stage_d.div_zero = (b == '0);
    stage_d.rem      = '0;
    stage_d.acc      = a;
    stage_d.dvs      = b;
    stage_d.res      = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ===== rtl/core/alu16_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu16_div_cell
// One restoring-division step; other ops ride through unchanged.
// ----------------------------------------------------------------------------
module alu16_div_cell import alu16_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stage_t stage_i,
  output stage_t stage_o
);

  logic [WordW:0] shifted;
  logic [WordW:0] diff;
  logic           qbit;
  stage_t         stage_d, stage_q;

  always_comb begin
    shifted = {stage_i.rem, stage_i.acc[WordW-1]};
    diff    = shifted - {1'b0, stage_i.dvs};
    qbit    = ~diff[WordW] | shifted[WordW];
    stage_d = stage_i;
    if (stage_i.is_div) begin
      stage_d.rem = qbit ? diff[WordW-1:0] : shifted[WordW-1:0];
      stage_d.acc = {stage_i.acc[WordW-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ===== rtl/core/alu16_with_flags_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu16_with_flags_core
// 16-bit ALU with zero/negative/carry/overflow flags and a pipelined divider.
// ----------------------------------------------------------------------------
// Every opcode passes the front stage, all divide cells and the output register to done_o.
// Throughput: one request per cycle; busy is never raised.
// The fixed latency is set by the divide chain: one cell per quotient bit.
// Results are presented for one cycle; the receiver cannot stall.
// Reset (rst_ni low, async) empties the pipeline; no result follows it.
module alu16_with_flags_core import alu16_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  // chain[0] is the front stage, chain[NumCells] the last divide cell
  stage_t chain [NumCells+1];
  stage_t last;
  rsp_t   rsp_d, rsp_q;
  logic   done_q;

  // No backpressure anywhere: every slot advances each cycle.
  assign busy = 1'b0;

  alu16_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (start & ~busy),
    .req_i   (req_i),
    .stage_o (chain[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    alu16_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  assign last = chain[NumCells];

  // Final formatting: divide results take the quotient, or the
  // divide-by-zero pattern; everything else was finished up front.
  always_comb begin
    rsp_d = last.res;
    if (last.is_div) begin
      if (last.div_zero) begin
        rsp_d.result_word   = '0;
        rsp_d.zero_flag     = 1'b0;
        rsp_d.negative_flag = 1'b0;
        rsp_d.carry_flag    = 1'b1;
        rsp_d.overflow_flag = 1'b1;
      end else begin
        rsp_d.result_word   = last.acc;
        rsp_d.zero_flag     = (last.acc == '0);
        rsp_d.negative_flag = last.acc[WordW-1];
        rsp_d.carry_flag    = 1'b0;
        rsp_d.overflow_flag = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/core/alu16_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu16_checker
// Port-level checks on the ALU's fixed latency and flag consistency.
// ----------------------------------------------------------------------------
module alu16_checker import alu16_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input rsp_t rsp_o
);

  a_req_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##18 done_o)
    else $error("request without result after fixed latency");

  a_done_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 18))
    else $error("result without a matching request");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.zero_flag) |-> (rsp_o.result_word == '0))
    else $error("zero flag with nonzero result");

  a_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.negative_flag) |-> rsp_o.result_word[WordW-1])
    else $error("negative flag without sign bit");

endmodule

bind alu16_with_flags_core alu16_checker u_alu16_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// ===== test/alu16_flags_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu16_flags_checker
// Watches accepted requests and strobed results of the flag ALU, predicts the
// result word and flags of every request, and compares them in order.
// ----------------------------------------------------------------------------
module alu16_flags_checker import alu16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        done_i,
  input  rsp_t        rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  rsp_t alu_expected_q[$];
  int unsigned mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = alu_expected_q.size();

  function automatic rsp_t alu_predict(req_t rq);
    rsp_t        r;
    logic [16:0] sum;
    logic [31:0] wide;
    logic [3:0]  sh;
    logic        c;
    logic        v;
    logic [15:0] w;
    c   = 1'b0;
    v   = 1'b0;
    w   = '0;
    sh  = rq.shift_amount[3:0];
    sum = '0;
    wide = '0;
    case (rq.opcode)
      OP_ADD: begin
        sum = {1'b0, rq.operand_a} + {1'b0, rq.operand_b} + 17'(rq.add_carry);
        w = sum[15:0];
        c = sum[16];
        v = ~(rq.operand_a[15] ^ rq.operand_b[15]) & (rq.operand_a[15] ^ w[15]);
      end
      OP_SUB: begin
        w = rq.operand_a - rq.operand_b;
        c = rq.operand_a >= rq.operand_b;
        v = (rq.operand_a[15] ^ rq.operand_b[15]) & (rq.operand_a[15] ^ w[15]);
      end
      OP_AND: w = rq.operand_a & rq.operand_b;
      OP_OR:  w = rq.operand_a | rq.operand_b;
      OP_XOR: w = rq.operand_a ^ rq.operand_b;
      OP_NOT: w = ~rq.operand_a;
      OP_SHL: begin
        wide = {16'h0, rq.operand_a} << sh;
        w = wide[15:0];
        c = |wide[31:16];
      end
      OP_SHR: begin
        w = rq.operand_a >> sh;
        c = (sh == 4'd0) ? 1'b0 : rq.operand_a[sh - 4'd1];
      end
      OP_MUL: begin
        wide = {16'h0, rq.operand_a} * {16'h0, rq.operand_b};
        w = wide[15:0];
        c = |wide[31:16];
      end
      OP_DIV: begin
        if (rq.operand_b == '0) begin
          r = '{result_word: '0, zero_flag: 1'b0, negative_flag: 1'b0,
                carry_flag: 1'b1, overflow_flag: 1'b1};
          return r;
        end
        w = rq.operand_a / rq.operand_b;
      end
      default: begin
        r = '0;  // unused opcodes: all zero
        return r;
      end
    endcase
    r.result_word   = w;
    r.zero_flag     = (w == '0);
    r.negative_flag = (rq.opcode == OP_SHR) ? 1'b0 : w[15];
    r.carry_flag    = c;
    r.overflow_flag = v;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      alu_expected_q.delete();
      mismatches <= 0;
    end else begin
      if (done_i) begin
        if (alu_expected_q.size() == 0) begin
          if (mismatches < 10) $display("%0t: unexpected result %h", $time, rsp_i);
          mismatches <= mismatches + 1;
        end else begin
          exp_rsp = alu_expected_q.pop_front();
          if (rsp_i !== exp_rsp) begin
            if (mismatches < 10)
              $display({"%0t: result mismatch: exp word %h z%b n%b c%b v%b,",
                        " got word %h z%b n%b c%b v%b"},
                       $time, exp_rsp.result_word, exp_rsp.zero_flag,
                       exp_rsp.negative_flag, exp_rsp.carry_flag,
                       exp_rsp.overflow_flag,
                       rsp_i.result_word, rsp_i.zero_flag, rsp_i.negative_flag,
                       rsp_i.carry_flag, rsp_i.overflow_flag);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start_i && !busy_i) alu_expected_q.push_back(alu_predict(req_i));
    end
  end

endmodule

// ===== test/tb_alu16_with_flags_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alu16_with_flags_core
// Drives directed and random ALU requests with random idle gaps; a checker
// beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_alu16_with_flags_core;
  import alu16_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        done;
  rsp_t        rsp;
  int unsigned fail_count;
  int unsigned pending;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  alu16_with_flags_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done),
    .rsp_o (rsp)
  );

  alu16_flags_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req),
    .done_i      (done),
    .rsp_i       (rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Present one request and hold it until the block takes it. An optional
  // idle cycle goes in front, with start low.
  task automatic send_request(req_t rq, bit allow_idle);
    if (allow_idle && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic req_t make_req(logic [3:0] op, logic [15:0] a, logic [15:0] b,
                                    logic ci, logic [7:0] sh);
    req_t rq;
    rq.opcode       = op;
    rq.operand_a    = a;
    rq.operand_b    = b;
    rq.add_carry    = ci;
    rq.shift_amount = sh;
    return rq;
  endfunction

  // Operands biased toward the corners where flags change.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'(1 << $urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    req_t rq;
    bit   quiet;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: operand extremes, every opcode, flag corners, unused opcodes.
    send_request(make_req(OP_ADD, 16'hFFFF, 16'h0001, 1'b0, 8'h00), 1'b0);
    send_request(make_req(OP_ADD, 16'h7FFF, 16'h0000, 1'b1, 8'hFF), 1'b0);
    send_request(make_req(OP_ADD, 16'h8000, 16'h8000, 1'b0, 8'h00), 1'b0);
    send_request(make_req(OP_ADD, 16'hFFFF, 16'hFFFF, 1'b1, 8'h00), 1'b0);
    send_request(make_req(OP_SUB, 16'h0000, 16'h0001, 1'b1, 8'h00), 1'b0);
    send_request(make_req(OP_SUB, 16'h8000, 16'h0001, 1'b0, 8'h00), 1'b0);
    send_request(make_req(OP_SUB, 16'h1234, 16'h1234, 1'b0, 8'h00), 1'b0);
    send_request(make_req(OP_AND, 16'hFFFF, 16'h0000, 1'b1, 8'h00), 1'b0);
    send_request(make_req(OP_OR,  16'h8000, 16'h0001, 1'b0, 8'h00), 1'b0);
    send_request(make_req(OP_XOR, 16'hFFFF, 16'hFFFF, 1'b0, 8'h00), 1'b0);
    send_request(make_req(OP_NOT, 16'h0000, 16'hFFFF, 1'b0, 8'h00), 1'b0);
    send_request(make_req(OP_SHL, 16'hFFFF, 16'h0000, 1'b0, 8'h0F), 1'b0);
    send_request(make_req(OP_SHL, 16'h0001, 16'h0000, 1'b0, 8'h10), 1'b0);
    send_request(make_req(OP_SHR, 16'hFFFF, 16'h0000, 1'b0, 8'h00), 1'b0);
    send_request(make_req(OP_SHR, 16'h8001, 16'h0000, 1'b0, 8'h01), 1'b0);
    send_request(make_req(OP_SHR, 16'h8000, 16'h0000, 1'b0, 8'hFF), 1'b0);
    send_request(make_req(OP_MUL, 16'hFFFF, 16'hFFFF, 1'b0, 8'h00), 1'b0);
    send_request(make_req(OP_MUL, 16'h00FF, 16'h0101, 1'b0, 8'h00), 1'b0);
    send_request(make_req(OP_DIV, 16'hFFFF, 16'h0000, 1'b1, 8'h00), 1'b0);
    send_request(make_req(OP_DIV, 16'h0000, 16'h0000, 1'b0, 8'h00), 1'b0);
    send_request(make_req(OP_DIV, 16'hFFFF, 16'h0001, 1'b0, 8'h00), 1'b0);
    send_request(make_req(OP_DIV, 16'h0003, 16'hFFFF, 1'b0, 8'h00), 1'b0);
    send_request(make_req(4'd10,  16'hFFFF, 16'hFFFF, 1'b1, 8'hFF), 1'b0);
    send_request(make_req(4'd15,  16'h1234, 16'h5678, 1'b0, 8'h0A), 1'b0);

    // Random: mostly legal opcodes; items 300..449 form a gap-free stretch.
    for (int i = 0; i < 850; i++) begin
      quiet = (i >= 300 && i < 450);
      rq.opcode       = ($urandom_range(9) == 0) ? 4'($urandom_range(10, 15))
                                                  : 4'($urandom_range(9));
      rq.operand_a    = pick_operand();
      rq.operand_b    = (rq.opcode == OP_DIV && $urandom_range(5) == 0) ? 16'h0000
                                                                        : pick_operand();
      rq.add_carry    = 1'($urandom);
      rq.shift_amount = 8'($urandom);
      send_request(rq, !quiet);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
